// File: sv/psu_pkg.sv
// ----------------------------------------------------------------------------
// psu_pkg
// Shared types, constants and helpers for the particle store update block.
// ----------------------------------------------------------------------------
package psu_pkg;

  localparam int PARTICLES = 64;
  localparam int SLOT_W    = $clog2(PARTICLES);
  localparam int FRAC_BITS = 16;
  localparam int Q_W       = FRAC_BITS + 1;
  localparam logic [Q_W-1:0] ONE_Q = Q_W'(1) << FRAC_BITS;
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(PARTICLES - 1);

  localparam logic OP_SPAWN = 1'b0;
  localparam logic OP_TICK  = 1'b1;

  localparam logic [1:0] ST_TICK    = 2'd0;
  localparam logic [1:0] ST_SPAWNED = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;

  localparam logic [1:0] CFG_GRAVITY  = 2'd0;
  localparam logic [1:0] CFG_FADE_IN  = 2'd1;
  localparam logic [1:0] CFG_FADE_OUT = 2'd2;

  typedef struct packed {
    logic               opcode;
    logic signed [31:0] spawn_x;
    logic signed [31:0] spawn_y;
    logic signed [31:0] spawn_z;
    logic signed [31:0] spawn_vx;
    logic signed [31:0] spawn_vy;
    logic signed [31:0] spawn_vz;
    logic [30:0]        lifetime;
    logic signed [31:0] rotation_rate;
    logic [30:0]        delta_time;
  } in_item_t;

  typedef struct packed {
    logic [SLOT_W-1:0]  slot;
    logic               live;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] rotation;
    logic [Q_W-1:0]     age_fraction;
    logic [Q_W-1:0]     alpha;
    logic [1:0]         status;
    logic               last;
  } out_item_t;

  typedef struct packed {
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] pz;
    logic signed [31:0] rot;
    logic signed [31:0] vx;
    logic signed [31:0] vy;
    logic signed [31:0] vz;
    logic signed [31:0] spin;
    logic signed [31:0] age;
    logic signed [31:0] life;
    logic signed [31:0] fie;
    logic signed [31:0] fos;
  } entry_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SP_MUL,
    S_SP_WR,
    S_T_RD,
    S_T_CHK,
    S_T_MUL,
    S_T_DIVS,
    S_T_DIVW,
    S_T_EMIT
  } state_t;

  typedef struct packed {
    logic              load;
    logic              sp_mul;
    logic              sp_wr;
    logic              rd;
    logic              chk;
    logic              mul_en;
    logic [2:0]        mul_step;
    logic              div_start;
    logic              emit_live;
    logic [SLOT_W-1:0] slot;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic dead;
    logic div_done;
  } stat_t;

  function automatic logic signed [31:0] sat32(input logic signed [67:0] v);
    if (v > 68'sh7FFFFFFF) begin
      return 32'sh7FFFFFFF;
    end else if (v < -68'sh80000000) begin
      return 32'sh80000000;
    end else begin
      return v[31:0];
    end
  endfunction

endpackage

// File: sv/psu_div.sv
// ----------------------------------------------------------------------------
// psu_div
// Saturating fixed-point ratio, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module psu_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic signed [31:0]         num,
  input  logic signed [31:0]         den,
  output logic [psu_pkg::Q_W-1:0]    quot,
  output logic                       done
);

  localparam int CNT_W = $clog2(psu_pkg::FRAC_BITS + 1);

  logic             run;
  logic [CNT_W-1:0] cnt;
  logic [32:0]      rem;
  logic [32:0]      dv;
  logic [32:0]      rem_sh;
  logic             ge;

  assign rem_sh = {rem[31:0], 1'b0};
  assign ge     = rem_sh >= dv;

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
      run  <= 1'b0;
    end else if (start) begin
      if (num <= 0) begin
        quot <= '0;
        done <= 1'b1;
        run  <= 1'b0;
      end else if (den <= 0 || num >= den) begin
        quot <= psu_pkg::ONE_Q;
        done <= 1'b1;
        run  <= 1'b0;
      end else begin
        rem  <= {1'b0, num};
        dv   <= {1'b0, den};
        cnt  <= CNT_W'(psu_pkg::FRAC_BITS);
        quot <= '0;
        done <= 1'b0;
        run  <= 1'b1;
      end
    end else if (run) begin
      rem  <= ge ? rem_sh - dv : rem_sh;
      quot <= {quot[psu_pkg::Q_W-2:0], ge};
      cnt  <= cnt - CNT_W'(1);
      if (cnt == CNT_W'(1)) begin
        run  <= 1'b0;
        done <= 1'b1;
      end
    end
  end

endmodule

// File: sv/psu_datapath.sv
// ----------------------------------------------------------------------------
// psu_datapath
// Particle memory, valid bits, shared multiplier, ratio units and result
// register.
// ----------------------------------------------------------------------------
module psu_datapath (
  input  logic                clk,
  input  logic                rst,
  input  psu_pkg::in_item_t   item,
  input  logic                cfg_wr,
  input  logic [1:0]          cfg_index,
  input  logic [31:0]         cfg_data,
  input  psu_pkg::cmd_t       cmd,
  output psu_pkg::stat_t      stat,
  output psu_pkg::out_item_t  result,
  output logic                result_strobe
);

  logic signed [31:0] gravity;
  logic [16:0]        fade_in_fraction;
  logic [16:0]        fade_out_fraction;

  psu_pkg::in_item_t  inr;
  logic [47:0]        prod_in;
  logic [47:0]        prod_out;
  logic [psu_pkg::PARTICLES-1:0] valid;

  psu_pkg::entry_t mem [psu_pkg::PARTICLES];
  psu_pkg::entry_t mem_q;
  psu_pkg::entry_t w;
  psu_pkg::entry_t spawn_e;

  logic [psu_pkg::SLOT_W-1:0] free_slot;
  logic                       full;
  logic [47:0]                fin_sh;
  logic [47:0]                fout_sh;

  logic signed [32:0] mul_a;
  logic signed [32:0] mul_b;
  logic signed [65:0] mp;
  logic signed [65:0] sh;
  logic signed [32:0] dt;

  logic signed [31:0] op_num;
  logic signed [31:0] op_den;
  logic signed [31:0] af_num;
  logic signed [31:0] af_den;
  logic [psu_pkg::Q_W-1:0] op_q;
  logic [psu_pkg::Q_W-1:0] af_q;
  logic op_done;
  logic af_done;

  logic                       we;
  logic [psu_pkg::SLOT_W-1:0] waddr;
  psu_pkg::entry_t            wdata;

  psu_pkg::out_item_t         result_next;
  logic                       strobe_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      gravity           <= '0;
      fade_in_fraction  <= '0;
      fade_out_fraction <= '0;
    end else if (cfg_wr) begin
      case (cfg_index)
        psu_pkg::CFG_GRAVITY:  gravity <= cfg_data;
        psu_pkg::CFG_FADE_IN:  fade_in_fraction <= cfg_data[16:0];
        psu_pkg::CFG_FADE_OUT: fade_out_fraction <= cfg_data[16:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    free_slot = '0;
    for (int i = psu_pkg::PARTICLES - 1; i >= 0; i--) begin
      if (!valid[i]) begin
        free_slot = psu_pkg::SLOT_W'(i);
      end
    end
    full = &valid;
  end

  assign fin_sh  = prod_in >> psu_pkg::FRAC_BITS;
  assign fout_sh = prod_out >> psu_pkg::FRAC_BITS;

  always_comb begin
    spawn_e      = '0;
    spawn_e.px   = inr.spawn_x;
    spawn_e.py   = inr.spawn_y;
    spawn_e.pz   = inr.spawn_z;
    spawn_e.vx   = inr.spawn_vx;
    spawn_e.vy   = inr.spawn_vy;
    spawn_e.vz   = inr.spawn_vz;
    spawn_e.spin = inr.rotation_rate;
    spawn_e.life = {1'b0, inr.lifetime};
    spawn_e.fie  = psu_pkg::sat32($signed({20'b0, fin_sh}));
    spawn_e.fos  = psu_pkg::sat32($signed({37'b0, inr.lifetime})
                                  - $signed({20'b0, fout_sh}));
  end

  assign dt = $signed({2'b0, inr.delta_time});
  assign sh = mp >>> psu_pkg::FRAC_BITS;

  always_comb begin
    case (cmd.mul_step)
      3'd0: begin
        mul_a = 33'(gravity);
        mul_b = 33'(w.age);
      end
      3'd1: begin
        mul_a = 33'(w.vx);
        mul_b = dt;
      end
      3'd2: begin
        mul_a = 33'(w.vy);
        mul_b = dt;
      end
      3'd3: begin
        mul_a = 33'(w.vz);
        mul_b = dt;
      end
      default: begin
        mul_a = 33'(w.spin);
        mul_b = dt;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      inr <= item;
    end
    if (cmd.sp_mul) begin
      prod_in  <= 48'(inr.lifetime) * 48'(fade_in_fraction);
      prod_out <= 48'(inr.lifetime) * 48'(fade_out_fraction);
    end
    if (cmd.chk) begin
      w <= mem_q;
    end else if (cmd.mul_en) begin
      if (cmd.mul_step <= 3'd4) begin
        mp <= mul_a * mul_b;
      end
      case (cmd.mul_step)
        3'd1: w.vy <= psu_pkg::sat32(68'(w.vy) - 68'(sh));
        3'd2: w.px <= psu_pkg::sat32(68'(w.px) + 68'(sh));
        3'd3: w.py <= psu_pkg::sat32(68'(w.py) + 68'(sh));
        3'd4: w.pz <= psu_pkg::sat32(68'(w.pz) + 68'(sh));
        3'd5: begin
          w.rot <= psu_pkg::sat32(68'(w.rot) + 68'(sh));
          w.age <= psu_pkg::sat32(68'(w.age) + 68'(dt));
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    op_num = 32'sd1;
    op_den = 32'sd0;
    if (w.age <= w.fie) begin
      if (w.fie != 0) begin
        op_num = w.age;
        op_den = w.fie;
      end
    end else if (w.age >= w.fos) begin
      if (w.age != 0) begin
        op_num = w.fos;
        op_den = w.age;
      end
    end
    if (w.life == 0) begin
      af_num = 32'sd1;
      af_den = 32'sd0;
    end else begin
      af_num = w.age;
      af_den = w.life;
    end
  end

  psu_div u_div_op (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.div_start),
    .num   (op_num),
    .den   (op_den),
    .quot  (op_q),
    .done  (op_done)
  );

  psu_div u_div_af (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.div_start),
    .num   (af_num),
    .den   (af_den),
    .quot  (af_q),
    .done  (af_done)
  );

  assign we    = (cmd.sp_wr && !full) || cmd.emit_live;
  assign waddr = cmd.sp_wr ? free_slot : cmd.slot;
  assign wdata = cmd.sp_wr ? spawn_e : w;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (cmd.rd) begin
      mem_q <= mem[cmd.slot];
    end
  end

  assign stat.full     = full;
  assign stat.dead     = !valid[cmd.slot] || (mem_q.age >= mem_q.life);
  assign stat.div_done = op_done && af_done;

  always_comb begin
    result_next = result;
    strobe_next = 1'b0;
    if (cmd.sp_wr) begin
      strobe_next      = 1'b1;
      result_next      = '0;
      result_next.last = 1'b1;
      if (full) begin
        result_next.status = psu_pkg::ST_FULL;
      end else begin
        result_next.slot   = free_slot;
        result_next.live   = 1'b1;
        result_next.pos_x  = inr.spawn_x;
        result_next.pos_y  = inr.spawn_y;
        result_next.pos_z  = inr.spawn_z;
        result_next.status = psu_pkg::ST_SPAWNED;
      end
    end else if (cmd.chk && stat.dead) begin
      strobe_next        = 1'b1;
      result_next        = '0;
      result_next.slot   = cmd.slot;
      result_next.status = psu_pkg::ST_TICK;
      result_next.last   = cmd.slot == psu_pkg::LAST_SLOT;
    end else if (cmd.emit_live) begin
      strobe_next              = 1'b1;
      result_next.slot         = cmd.slot;
      result_next.live         = 1'b1;
      result_next.pos_x        = w.px;
      result_next.pos_y        = w.py;
      result_next.pos_z        = w.pz;
      result_next.rotation     = w.rot;
      result_next.age_fraction = af_q;
      result_next.alpha        = op_q;
      result_next.status       = psu_pkg::ST_TICK;
      result_next.last         = cmd.slot == psu_pkg::LAST_SLOT;
    end
  end

  always_ff @(posedge clk) begin
    result <= result_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid         <= '0;
      result_strobe <= 1'b0;
    end else begin
      result_strobe <= strobe_next;
      if (cmd.sp_wr && !full) begin
        valid[free_slot] <= 1'b1;
      end else if (cmd.chk && stat.dead) begin
        valid[cmd.slot] <= 1'b0;
      end
    end
  end

endmodule

// File: sv/psu_ctrl.sv
// ----------------------------------------------------------------------------
// psu_ctrl
// Sequencer for spawn and tick requests, walking the slots one at a time.
// ----------------------------------------------------------------------------
module psu_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic            opcode,
  input  psu_pkg::stat_t  stat,
  output psu_pkg::cmd_t   cmd,
  output logic            busy
);

  psu_pkg::state_t            state;
  psu_pkg::state_t            state_next;
  logic [psu_pkg::SLOT_W-1:0] slot;
  logic [psu_pkg::SLOT_W-1:0] slot_next;
  logic [2:0]                 step;
  logic [2:0]                 step_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= psu_pkg::S_IDLE;
      slot  <= '0;
      step  <= '0;
    end else begin
      state <= state_next;
      slot  <= slot_next;
      step  <= step_next;
    end
  end

  always_comb begin
    state_next   = state;
    slot_next    = slot;
    step_next    = step;
    cmd          = '0;
    cmd.slot     = slot;
    cmd.mul_step = step;
    case (state)
      psu_pkg::S_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          slot_next  = '0;
          state_next = (opcode == psu_pkg::OP_SPAWN) ? psu_pkg::S_SP_MUL : psu_pkg::S_T_RD;
        end
      end
      psu_pkg::S_SP_MUL: begin
        cmd.sp_mul = 1'b1;
        state_next = psu_pkg::S_SP_WR;
      end
      psu_pkg::S_SP_WR: begin
        cmd.sp_wr  = 1'b1;
        state_next = psu_pkg::S_IDLE;
      end
      psu_pkg::S_T_RD: begin
        cmd.rd     = 1'b1;
        state_next = psu_pkg::S_T_CHK;
      end
      psu_pkg::S_T_CHK: begin
        cmd.chk = 1'b1;
        if (stat.dead) begin
          slot_next  = slot + 1'b1;
          state_next = (slot == psu_pkg::LAST_SLOT) ? psu_pkg::S_IDLE : psu_pkg::S_T_RD;
        end else begin
          step_next  = '0;
          state_next = psu_pkg::S_T_MUL;
        end
      end
      psu_pkg::S_T_MUL: begin
        cmd.mul_en = 1'b1;
        if (step == 3'd5) begin
          state_next = psu_pkg::S_T_DIVS;
        end else begin
          step_next = step + 3'd1;
        end
      end
      psu_pkg::S_T_DIVS: begin
        cmd.div_start = 1'b1;
        state_next    = psu_pkg::S_T_DIVW;
      end
      psu_pkg::S_T_DIVW: begin
        if (stat.div_done) begin
          state_next = psu_pkg::S_T_EMIT;
        end
      end
      psu_pkg::S_T_EMIT: begin
        cmd.emit_live = 1'b1;
        slot_next     = slot + 1'b1;
        state_next    = (slot == psu_pkg::LAST_SLOT) ? psu_pkg::S_IDLE : psu_pkg::S_T_RD;
      end
      default: begin
        state_next = psu_pkg::S_IDLE;
      end
    endcase
  end

  assign busy = state != psu_pkg::S_IDLE;

endmodule

// File: sv/particle_store_update.sv
// ----------------------------------------------------------------------------
// particle_store_update
// Particle store with Euler position, spin, age and fade update.
// ----------------------------------------------------------------------------
// A spawn request returns its one result after the load, multiply and write states.
// A tick request returns one result per slot: an empty slot passes through the
// read and check states, a live one also through six shared multiplier steps and
// the 16-step ratio units.
// Synchronous reset clears the valid bits, configuration, sequencer state and result strobe; results cannot stall.
module particle_store_update (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  psu_pkg::in_item_t   item,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [1:0]          cfg_index,
  input  logic [31:0]         cfg_data,
  output psu_pkg::out_item_t  result,
  output logic                result_strobe
);

  psu_pkg::cmd_t  cmd;
  psu_pkg::stat_t stat;

  assign cfg_ready = 1'b1;

  psu_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .opcode (item.opcode),
    .stat   (stat),
    .cmd    (cmd),
    .busy   (busy)
  );

  psu_datapath u_dp (
    .clk           (clk),
    .rst           (rst),
    .item          (item),
    .cfg_wr        (cfg_valid && cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .cmd           (cmd),
    .stat          (stat),
    .result        (result),
    .result_strobe (result_strobe)
  );

  a_tick_last_slot: assert property (@(posedge clk) disable iff (rst)
    (result_strobe && result.status == psu_pkg::ST_TICK && result.last)
      |-> result.slot == psu_pkg::LAST_SLOT)
    else $error("Tick request ended before the last slot.");

  a_spawn_single: assert property (@(posedge clk) disable iff (rst)
    (result_strobe && result.status != psu_pkg::ST_TICK) |-> result.last)
    else $error("Spawn request produced more than one result.");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("Accepted request did not make the block busy.");

  a_dead_zero: assert property (@(posedge clk) disable iff (rst)
    (result_strobe && !result.live)
      |-> (result.pos_x == 0 && result.alpha == 0 && result.age_fraction == 0))
    else $error("Result for an empty slot carries data.");

endmodule

// File: verif/particle_store_update_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// particle_store_update_tb
// Self-checking bench for the particle store: spawns and ticks are predicted
// in Q16.16 fixed point and every slot report is compared field by field.
// ----------------------------------------------------------------------------
module particle_store_update_tb;

  logic               clk;
  logic               rst;
  logic               start;
  logic               busy;
  psu_pkg::in_item_t  item;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [1:0]         cfg_index;
  logic [31:0]        cfg_data;
  psu_pkg::out_item_t result;
  logic               result_strobe;

  particle_store_update dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .item(item),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .result(result), .result_strobe(result_strobe)
  );

  // Predicted particle state.
  logic signed [31:0] m_gravity;
  logic [16:0] m_fin, m_fout;
  logic signed [31:0] m_px[psu_pkg::PARTICLES], m_py[psu_pkg::PARTICLES];
  logic signed [31:0] m_pz[psu_pkg::PARTICLES], m_rot[psu_pkg::PARTICLES];
  logic signed [31:0] m_vx[psu_pkg::PARTICLES], m_vy[psu_pkg::PARTICLES];
  logic signed [31:0] m_vz[psu_pkg::PARTICLES], m_spin[psu_pkg::PARTICLES];
  logic signed [31:0] m_age[psu_pkg::PARTICLES], m_life[psu_pkg::PARTICLES];
  logic signed [31:0] m_fie[psu_pkg::PARTICLES], m_fos[psu_pkg::PARTICLES];
  logic m_alive[psu_pkg::PARTICLES];

  psu_pkg::out_item_t expected_reports[$];
  int errors;
  int mismatches;
  longint cycles;
  bit quiet;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > 64'd3000000) begin
        $display("** particle_store_update: FAILED **");
        $finish;
      end
    end
  end

  function automatic logic signed [31:0] clamp32(input longint v);
    if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic longint qmul(input longint a, input longint b);
    return (a * b) >>> psu_pkg::FRAC_BITS;
  endfunction

  function automatic logic [16:0] qratio(input longint num, input longint den);
    longint q;
    if (num <= 0) return 17'd0;
    if (den <= 0) return psu_pkg::ONE_Q;
    q = (num <<< psu_pkg::FRAC_BITS) / den;
    if (q > 65536) q = 65536;
    return q[16:0];
  endfunction

  task automatic clear_model();
    m_gravity = '0;
    m_fin = '0;
    m_fout = '0;
    for (int i = 0; i < psu_pkg::PARTICLES; i++) m_alive[i] = 1'b0;
  endtask

  task automatic predict_item(input psu_pkg::in_item_t it);
    psu_pkg::out_item_t r;
    longint life, dt;
    logic [16:0] op;
    int s;
    if (it.opcode == psu_pkg::OP_SPAWN) begin
      r = '0;
      r.last = 1'b1;
      s = -1;
      for (int i = 0; i < psu_pkg::PARTICLES; i++) begin
        if (!m_alive[i] && s < 0) s = i;
      end
      if (s < 0) begin
        r.status = psu_pkg::ST_FULL;
      end else begin
        life = longint'(it.lifetime);
        m_px[s] = it.spawn_x; m_py[s] = it.spawn_y; m_pz[s] = it.spawn_z;
        m_vx[s] = it.spawn_vx; m_vy[s] = it.spawn_vy; m_vz[s] = it.spawn_vz;
        m_life[s] = life[31:0]; m_spin[s] = it.rotation_rate;
        m_rot[s] = '0; m_age[s] = '0;
        m_fie[s] = clamp32(qmul(life, longint'(m_fin)));
        m_fos[s] = clamp32(life - qmul(life, longint'(m_fout)));
        m_alive[s] = 1'b1;
        r.slot = psu_pkg::SLOT_W'(s); r.live = 1'b1; r.status = psu_pkg::ST_SPAWNED;
        r.pos_x = it.spawn_x; r.pos_y = it.spawn_y; r.pos_z = it.spawn_z;
      end
      expected_reports.push_back(r);
    end else begin
      dt = longint'(it.delta_time);
      for (int i = 0; i < psu_pkg::PARTICLES; i++) begin
        r = '0;
        r.slot = psu_pkg::SLOT_W'(i);
        r.status = psu_pkg::ST_TICK;
        r.last = (i == psu_pkg::PARTICLES - 1);
        if (m_alive[i] && m_age[i] >= m_life[i]) m_alive[i] = 1'b0;
        if (m_alive[i]) begin
          m_vy[i] = clamp32(longint'(m_vy[i]) - qmul(m_gravity, m_age[i]));
          m_px[i] = clamp32(longint'(m_px[i]) + qmul(m_vx[i], dt));
          m_py[i] = clamp32(longint'(m_py[i]) + qmul(m_vy[i], dt));
          m_pz[i] = clamp32(longint'(m_pz[i]) + qmul(m_vz[i], dt));
          m_rot[i] = clamp32(longint'(m_rot[i]) + qmul(m_spin[i], dt));
          m_age[i] = clamp32(longint'(m_age[i]) + dt);
          if (m_age[i] <= m_fie[i]) begin
            op = (m_fie[i] == 0) ? psu_pkg::ONE_Q : qratio(m_age[i], m_fie[i]);
          end else if (m_age[i] >= m_fos[i]) begin
            op = (m_age[i] == 0) ? psu_pkg::ONE_Q : qratio(m_fos[i], m_age[i]);
          end else begin
            op = psu_pkg::ONE_Q;
          end
          r.live = 1'b1;
          r.pos_x = m_px[i]; r.pos_y = m_py[i]; r.pos_z = m_pz[i];
          r.rotation = m_rot[i];
          r.age_fraction = (m_life[i] == 0) ? psu_pkg::ONE_Q
                                            : qratio(m_age[i], m_life[i]);
          r.alpha = op;
        end
        expected_reports.push_back(r);
      end
    end
  endtask

  // Result checker.
  initial begin
    psu_pkg::out_item_t want;
    forever begin
      @(posedge clk);
      if (!rst && result_strobe) begin
        if (expected_reports.size() == 0) begin
          errors++;
          if (mismatches < 10) $display("unexpected result %p", result);
          mismatches++;
        end else begin
          want = expected_reports.pop_front();
          if (result.slot !== want.slot || result.live !== want.live ||
              result.pos_x !== want.pos_x || result.pos_y !== want.pos_y ||
              result.pos_z !== want.pos_z || result.rotation !== want.rotation ||
              result.age_fraction !== want.age_fraction ||
              result.alpha !== want.alpha || result.status !== want.status ||
              result.last !== want.last) begin
            errors++;
            if (mismatches < 10) $display("mismatch exp %p act %p", want, result);
            mismatches++;
          end
        end
      end
    end
  end

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == psu_pkg::CFG_GRAVITY) m_gravity = val;
    else if (idx == psu_pkg::CFG_FADE_IN) m_fin = val[16:0];
    else if (idx == psu_pkg::CFG_FADE_OUT) m_fout = val[16:0];
    @(posedge clk);
  endtask

  task automatic send_item(input psu_pkg::in_item_t it);
    if (!quiet && $urandom_range(99) < 6) begin
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    start <= 1'b1;
    item <= it;
    do @(posedge clk); while (busy);
    predict_item(it);
    start <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain();
    while (expected_reports.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_q();
    case ($urandom_range(5))
      0: return 32'h7FFFFFFF;
      1: return 32'h80000000;
      2: return $urandom;
      default: return $signed($urandom_range(0, 32'h3FFFF)) - 32'sh20000;
    endcase
  endfunction

  function automatic psu_pkg::in_item_t make_spawn(input logic [30:0] life);
    psu_pkg::in_item_t it;
    it = '0;
    it.opcode = psu_pkg::OP_SPAWN;
    it.spawn_x = rand_q(); it.spawn_y = rand_q(); it.spawn_z = rand_q();
    it.spawn_vx = rand_q(); it.spawn_vy = rand_q(); it.spawn_vz = rand_q();
    it.rotation_rate = rand_q();
    it.lifetime = life;
    it.delta_time = 31'($urandom);
    return it;
  endfunction

  function automatic psu_pkg::in_item_t make_tick(input logic [30:0] dt);
    psu_pkg::in_item_t it;
    it = make_spawn(31'($urandom));
    it.opcode = psu_pkg::OP_TICK;
    it.delta_time = dt;
    return it;
  endfunction

  task automatic test_directed();
    psu_pkg::in_item_t it;
    write_reg(psu_pkg::CFG_GRAVITY, 32'h0000_8000);
    write_reg(psu_pkg::CFG_FADE_IN, 32'h0000_4000);
    write_reg(psu_pkg::CFG_FADE_OUT, 32'h0000_4000);
    send_item(make_tick(31'h1_0000));
    it = make_spawn(31'h4_0000);
    it.spawn_x = 32'h7FFFFFFF; it.spawn_y = 32'h80000000; it.spawn_vx = 32'h7FFFFFFF;
    it.spawn_vy = 32'h80000000; it.rotation_rate = 32'hFFFFFFFF;
    send_item(it);
    send_item(make_spawn(31'd0));
    send_item(make_spawn(31'h7FFFFFFF));
    send_item(make_tick(31'h7FFFFFFF));
    send_item(make_tick(31'd0));
    send_item(make_tick(31'h0_8000));
    send_item(make_tick(31'h1_0000));
  endtask

  task automatic test_full_store();
    for (int i = 0; i < psu_pkg::PARTICLES + 2; i++) send_item(make_spawn(31'h7FFF_0000));
    send_item(make_tick(31'h1000));
    drain();
    write_reg(psu_pkg::CFG_GRAVITY, 32'h8000_0000);
    write_reg(psu_pkg::CFG_FADE_IN, 32'h1_0000);
    write_reg(psu_pkg::CFG_FADE_OUT, 32'h1_0000);
    send_item(make_tick(31'h7FFFFFFF));
    send_item(make_tick(31'h1));
    send_item(make_tick(31'h1));
  endtask

  task automatic test_random(input int count);
    psu_pkg::in_item_t it;
    for (int n = 0; n < count; n++) begin
      if (n % 80 == 40) begin
        drain();
        write_reg(psu_pkg::CFG_GRAVITY, $urandom_range(3) == 0 ? 32'h7FFFFFFF : rand_q());
        write_reg(psu_pkg::CFG_FADE_IN, $urandom_range(0, 32'h1FFFF));
        write_reg(psu_pkg::CFG_FADE_OUT, $urandom_range(0, 32'h1_0000));
      end
      quiet = (n >= 150 && n < 200);
      if ($urandom_range(3) == 0) begin
        it = make_tick(31'($urandom_range(2) == 0 ? $urandom
                                                 : $urandom_range(0, 32'h2_0000)));
      end else begin
        it = make_spawn(31'($urandom_range(3) == 0 ? $urandom
                                                   : $urandom_range(0, 32'h8_0000)));
      end
      send_item(it);
    end
    quiet = 1'b0;
  endtask

  initial begin
    errors = 0;
    mismatches = 0;
    quiet = 1'b0;
    rst <= 1'b1;
    start <= 1'b0;
    item <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= psu_pkg::CFG_GRAVITY;
    cfg_data <= '0;
    clear_model();
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    drain();
    test_full_store();
    drain();
    test_random(252);
    drain();
    if (errors == 0) begin
      $display("** particle_store_update: PASSED **");
    end else begin
      $display("** particle_store_update: FAILED **");
    end
    $finish;
  end

endmodule

// File: particle_store_update.f
sv/psu_pkg.sv
sv/psu_div.sv
sv/psu_datapath.sv
sv/psu_ctrl.sv
sv/particle_store_update.sv
verif/particle_store_update_tb.sv
